>>> rtl/bfa_pkg.sv
package bfa_pkg;

    // Fixed widths of the stream fields.
    localparam int SIZE_W     = 11;
    localparam int IDX_IN_W   = 6;
    localparam int BASE_OUT_W = 10;
    localparam int LEN_OUT_W  = 11;
    localparam int STATUS_W   = 3;

    // Defaults for the top-level parameters and the size limit register.
    localparam int MEM_BYTES_DEF  = 1024;
    localparam int MAX_BLOCKS_DEF = 64;
    localparam logic [SIZE_W-1:0] MAX_ALLOC_RESET = 11'd50;

    // Request kinds carried on the input tuser.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC     = 3'd0,
        ST_FREED     = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_LOAD,
        CMD_URD,
        CMD_UCAP,
        CMD_SCAN,
        CMD_ALLOC_WR,
        CMD_FDN,
        CMD_UPREP,
        CMD_UDN,
        CMD_MERGE_WR,
        CMD_UPPREP,
        CMD_FUP,
        CMD_INSERT,
        CMD_DONE
    } dp_op_t;

    typedef struct packed {
        dp_op_t  op;
        status_t status;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic used_full;
        logic free_full;
        logic idx_bad;
        logic found;
        logic exact;
        logic merge_prev;
        logic merge_next;
        logic done;
    } dp_stat_t;

endpackage

>>> rtl/bfa_ram.sv
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/bfa_datapath.sv
module bfa_datapath
    import bfa_pkg::*;
#(
    parameter int MEM_BYTES  = MEM_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [SIZE_W-1:0]     cfg_data,
    input  logic                  in_func,
    input  logic [SIZE_W-1:0]     in_req_size,
    input  logic [IDX_IN_W-1:0]   in_used_index,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [BASE_OUT_W-1:0] out_base,
    output logic [LEN_OUT_W-1:0]  out_len
);

    localparam int AW   = $clog2(MEM_BYTES);
    localparam int LW   = $clog2(MEM_BYTES + 1);
    localparam int IW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int EW   = AW + LW;
    localparam int CMPW = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int IXW  = (CW > IDX_IN_W) ? CW : IDX_IN_W;

    logic [SIZE_W-1:0]   max_alloc_reg;
    logic [CW-1:0]       fc_reg;
    logic [CW-1:0]       uc_reg;
    logic                pend_reg;
    logic                func_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [IDX_IN_W-1:0] idx_reg;
    logic [CW-1:0]       ptr_reg;
    logic [CW-1:0]       pidx_reg;
    logic                found_reg;
    logic [CW-1:0]       best_reg;
    logic [AW-1:0]       bbase_reg;
    logic [LW-1:0]       blen_reg;
    logic [AW-1:0]       ubase_reg;
    logic [LW-1:0]       ulen_reg;
    logic [CW-1:0]       pos_reg;
    logic [AW-1:0]       pbase_reg;
    logic [LW-1:0]       plen_reg;
    logic                nfound_reg;
    logic [AW-1:0]       nbase_reg;
    logic [LW-1:0]       nlen_reg;
    logic [BASE_OUT_W-1:0] out_base_reg;
    logic [LEN_OUT_W-1:0]  out_len_reg;

    logic          free_we;
    logic [IW-1:0] free_wa;
    logic [EW-1:0] free_wd;
    logic [IW-1:0] free_ra;
    logic [EW-1:0] free_rd;
    logic          used_we;
    logic [IW-1:0] used_wa;
    logic [EW-1:0] used_wd;
    logic [IW-1:0] used_ra;
    logic [EW-1:0] used_rd;

    logic [CW-1:0]     ptr_p1;
    logic [CW-1:0]     ptr_m1;
    logic [CW-1:0]     pos_m1;
    logic              issue;
    logic              done;
    logic              exact;
    logic              merge_prev;
    logic              merge_next;
    logic [LW-1:0]     merged_len;
    logic [AW-1:0]     rd_base;
    logic [LW-1:0]     rd_len;
    logic [SIZE_W-1:0] req_eff;
    logic [SIZE_W-1:0] lim_eff;
    logic [SIZE_W-1:0] size_clamp;

    bfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_free_ram (
        .clk     (clk),
        .wr_en   (free_we),
        .wr_addr (free_wa),
        .wr_data (free_wd),
        .rd_addr (free_ra),
        .rd_data (free_rd)
    );

    bfa_ram #(.WIDTH(EW), .DEPTH(MAX_BLOCKS)) u_used_ram (
        .clk     (clk),
        .wr_en   (used_we),
        .wr_addr (used_wa),
        .wr_data (used_wd),
        .rd_addr (used_ra),
        .rd_data (used_rd)
    );

    // Shared arithmetic and compares.
    assign ptr_p1  = ptr_reg + CW'(1);
    assign ptr_m1  = ptr_reg - CW'(1);
    assign pos_m1  = pos_reg - CW'(1);
    assign rd_base = free_rd[EW-1:LW];
    assign rd_len  = free_rd[LW-1:0];
    assign exact   = CMPW'(blen_reg) == CMPW'(size_reg);
    assign merge_prev = (pos_reg != '0) && ((LW'(pbase_reg) + plen_reg) == LW'(ubase_reg));
    assign merge_next = nfound_reg && ((LW'(ubase_reg) + ulen_reg) == LW'(nbase_reg));
    assign merged_len = plen_reg + ulen_reg + (merge_next ? nlen_reg : '0);

    // Request size clamp: zero is taken as one, then limited to max_alloc.
    assign req_eff    = (in_req_size == '0) ? SIZE_W'(1) : in_req_size;
    assign lim_eff    = (max_alloc_reg == '0) ? SIZE_W'(1) : max_alloc_reg;
    assign size_clamp = (req_eff > lim_eff) ? lim_eff : req_eff;

    // A sweep issues one table read per cycle while entries remain.
    always_comb
    begin
        case (cmd.op)
            CMD_SCAN: issue = ptr_reg < fc_reg;
            CMD_FDN:  issue = ptr_p1 < fc_reg;
            CMD_UDN:  issue = ptr_p1 < uc_reg;
            CMD_FUP:  issue = ptr_reg > pos_reg;
            default:  issue = 1'b0;
        endcase
    end

    assign done = !pend_reg && !issue;

    // Table port selection.
    always_comb
    begin
        free_we = 1'b0;
        free_wa = pidx_reg[IW-1:0];
        free_wd = free_rd;
        free_ra = ptr_reg[IW-1:0];
        used_we = 1'b0;
        used_wa = pidx_reg[IW-1:0];
        used_wd = used_rd;
        used_ra = IW'(idx_reg);
        case (cmd.op)
            CMD_INIT:
            begin
                free_we = 1'b1;
                free_wa = '0;
                free_wd = {AW'(0), LW'(MEM_BYTES)};
            end
            CMD_ALLOC_WR:
            begin
                used_we = 1'b1;
                used_wa = uc_reg[IW-1:0];
                used_wd = {bbase_reg, LW'(size_reg)};
                free_we = !exact;
                free_wa = best_reg[IW-1:0];
                free_wd = {bbase_reg + AW'(size_reg), blen_reg - LW'(size_reg)};
            end
            CMD_FDN:
            begin
                free_ra = ptr_p1[IW-1:0];
                free_we = pend_reg;
            end
            CMD_FUP:
            begin
                free_ra = ptr_m1[IW-1:0];
                free_we = pend_reg;
            end
            CMD_UDN:
            begin
                used_ra = ptr_p1[IW-1:0];
                used_we = pend_reg;
            end
            CMD_MERGE_WR:
            begin
                free_we = 1'b1;
                if (merge_prev)
                begin
                    free_wa = pos_m1[IW-1:0];
                    free_wd = {pbase_reg, merged_len};
                end
                else
                begin
                    free_wa = pos_reg[IW-1:0];
                    free_wd = {ubase_reg, nlen_reg + ulen_reg};
                end
            end
            CMD_INSERT:
            begin
                free_we = 1'b1;
                free_wa = pos_reg[IW-1:0];
                free_wd = {ubase_reg, ulen_reg};
            end
            default:
            begin
                free_we = 1'b0;
            end
        endcase
    end

    // Counters, the size limit and the read pipeline flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_alloc_reg <= MAX_ALLOC_RESET;
            fc_reg        <= CW'(1);
            uc_reg        <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            pend_reg <= issue;
            if (cfg_valid)
            begin
                max_alloc_reg <= cfg_data;
            end
            if (cmd.op == CMD_ALLOC_WR)
            begin
                uc_reg <= uc_reg + CW'(1);
            end
            if (cmd.op == CMD_UDN && done)
            begin
                uc_reg <= uc_reg - CW'(1);
            end
            if (cmd.op == CMD_FDN && done)
            begin
                fc_reg <= fc_reg - CW'(1);
            end
            if (cmd.op == CMD_INSERT)
            begin
                fc_reg <= fc_reg + CW'(1);
            end
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            pidx_reg <= ptr_reg;
            ptr_reg  <= (cmd.op == CMD_FUP) ? ptr_m1 : ptr_p1;
        end
        case (cmd.op)
            CMD_LOAD:
            begin
                func_reg   <= in_func;
                size_reg   <= size_clamp;
                idx_reg    <= in_used_index;
                ptr_reg    <= '0;
                found_reg  <= 1'b0;
                pos_reg    <= '0;
                nfound_reg <= 1'b0;
            end
            CMD_UCAP:
            begin
                ubase_reg <= used_rd[EW-1:LW];
                ulen_reg  <= used_rd[LW-1:0];
            end
            CMD_SCAN:
            begin
                if (pend_reg)
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (CMPW'(rd_len) >= CMPW'(size_reg) &&
                            (!found_reg || rd_len < blen_reg))
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= pidx_reg;
                            bbase_reg <= rd_base;
                            blen_reg  <= rd_len;
                        end
                    end
                    else if (rd_base < ubase_reg)
                    begin
                        pos_reg   <= pidx_reg + CW'(1);
                        pbase_reg <= rd_base;
                        plen_reg  <= rd_len;
                    end
                    else if (!nfound_reg)
                    begin
                        nfound_reg <= 1'b1;
                        nbase_reg  <= rd_base;
                        nlen_reg   <= rd_len;
                    end
                end
            end
            CMD_ALLOC_WR:
            begin
                ptr_reg <= best_reg;
            end
            CMD_UPREP:
            begin
                ptr_reg <= CW'(idx_reg);
            end
            CMD_MERGE_WR:
            begin
                ptr_reg <= pos_reg;
            end
            CMD_UPPREP:
            begin
                ptr_reg <= fc_reg;
            end
            CMD_DONE:
            begin
                case (cmd.status)
                    ST_ALLOC:
                    begin
                        out_base_reg <= BASE_OUT_W'(bbase_reg);
                        out_len_reg  <= LEN_OUT_W'(size_reg);
                    end
                    ST_FREED:
                    begin
                        out_base_reg <= BASE_OUT_W'(ubase_reg);
                        out_len_reg  <= LEN_OUT_W'(ulen_reg);
                    end
                    default:
                    begin
                        out_base_reg <= '0;
                        out_len_reg  <= '0;
                    end
                endcase
            end
            default:
            begin
                pos_reg <= pos_reg;
            end
        endcase
    end

    // Status toward the controller.
    assign stat.is_free    = func_reg;
    assign stat.used_full  = uc_reg >= CW'(MAX_BLOCKS);
    assign stat.free_full  = fc_reg >= CW'(MAX_BLOCKS);
    assign stat.idx_bad    = IXW'(idx_reg) >= IXW'(uc_reg);
    assign stat.found      = found_reg;
    assign stat.exact      = exact;
    assign stat.merge_prev = merge_prev;
    assign stat.merge_next = merge_next;
    assign stat.done       = done;

    assign out_base = out_base_reg;
    assign out_len  = out_len_reg;

endmodule

>>> rtl/bfa_ctrl.sv
module bfa_ctrl
    import bfa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output status_t  out_status,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_CHECK,
        S_URD,
        S_UCAP,
        S_SCAN,
        S_DECIDE,
        S_AWR,
        S_FDN,
        S_UPREP,
        S_UDN,
        S_MERGE,
        S_FUP,
        S_INSERT,
        S_DONE
    } state_t;

    state_t  state_reg;
    state_t  state_next;
    status_t st_reg;
    status_t st_next;
    logic    out_valid_reg;
    status_t out_status_reg;
    logic    emit;

    assign in_ready   = state_reg == S_IDLE;
    assign emit       = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;

    // Next state and the command for this cycle.
    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = CMD_NONE;
        cmd.status = st_reg;
        case (state_reg)
            S_INIT:
            begin
                cmd.op     = CMD_INIT;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (!stat.is_free)
                begin
                    if (stat.used_full)
                    begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
                else if (stat.idx_bad)
                begin
                    st_next    = ST_BAD_INDEX;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_URD;
                end
            end
            S_URD:
            begin
                cmd.op     = CMD_URD;
                state_next = S_UCAP;
            end
            S_UCAP:
            begin
                cmd.op     = CMD_UCAP;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.op = CMD_SCAN;
                if (stat.done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (!stat.is_free)
                begin
                    if (stat.found)
                    begin
                        state_next = S_AWR;
                    end
                    else
                    begin
                        st_next    = ST_NO_FIT;
                        state_next = S_DONE;
                    end
                end
                else if (!stat.merge_prev && !stat.merge_next && stat.free_full)
                begin
                    st_next    = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_UPREP;
                end
            end
            S_AWR:
            begin
                cmd.op     = CMD_ALLOC_WR;
                st_next    = ST_ALLOC;
                state_next = stat.exact ? S_FDN : S_DONE;
            end
            S_FDN:
            begin
                cmd.op = CMD_FDN;
                if (stat.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_UPREP:
            begin
                cmd.op     = CMD_UPREP;
                state_next = S_UDN;
            end
            S_UDN:
            begin
                cmd.op = CMD_UDN;
                if (stat.done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                st_next = ST_FREED;
                if (stat.merge_prev || stat.merge_next)
                begin
                    cmd.op     = CMD_MERGE_WR;
                    state_next = (stat.merge_prev && stat.merge_next) ? S_FDN : S_DONE;
                end
                else
                begin
                    cmd.op     = CMD_UPPREP;
                    state_next = S_FUP;
                end
            end
            S_FUP:
            begin
                cmd.op = CMD_FUP;
                if (stat.done)
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.op     = CMD_INSERT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (emit)
                begin
                    cmd.op     = CMD_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and the registered result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            st_reg         <= ST_ALLOC;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_ALLOC;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
            if (emit)
            begin
                out_valid_reg  <= 1'b1;
                out_status_reg <= st_reg;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/best_fit_block_allocator.sv
// Best-fit block allocator over a byte region of MEM_BYTES bytes.
// Input stream: tuser is the request kind (allocate or free); tdata carries
// the requested size and the used-table position of the block to free.
// Output stream: tuser is the status code; tdata carries the base and the
// length of the block allocated or freed (both zero on an error).
// The cfg channel writes the per-request size limit; it is always ready. The
// user must write it only while no request is in progress; the block does not enforce this.
// Each request walks the free table through one RAM read port, one entry per
// cycle, so the time to a result follows the table fill. An allocate scans the
// free table and, when an exact fit removes an entry, shifts the rest down; a
// free reads its used entry, scans, shifts the used table, then merges into the
// free table or shifts it to insert. A full used table on an allocate or a bad
// index is found before the scan. One request is in progress at a time.
// After reset the free table is loaded with one block spanning the region,
// in an init state before the first transfer is accepted.
// A finished result sits in the output register until it is taken; the next
// request is accepted meanwhile, but its result waits for the register.
module best_fit_block_allocator
    import bfa_pkg::*;
#(
    parameter int MEM_BYTES  = MEM_BYTES_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [SIZE_W-1:0] cfg_data,       // max_alloc
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [23:0]       s_axis_tdata,   // req_size[10:0], used_index[16:11]
    input  logic              s_axis_tuser,   // func
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [23:0]       m_axis_tdata,   // block_base[9:0], block_len[20:10]
    output logic [2:0]        m_axis_tuser    // status
);

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    status_t               out_status;
    logic [BASE_OUT_W-1:0] out_base;
    logic [LEN_OUT_W-1:0]  out_len;

    assign cfg_ready = 1'b1;

    bfa_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_status (out_status),
        .cmd        (cmd),
        .stat       (stat)
    );

    bfa_datapath #(
        .MEM_BYTES  (MEM_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .in_func       (s_axis_tuser),
        .in_req_size   (s_axis_tdata[10:0]),
        .in_used_index (s_axis_tdata[16:11]),
        .cmd           (cmd),
        .stat          (stat),
        .out_base      (out_base),
        .out_len       (out_len)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, out_len, out_base};
    assign m_axis_tuser = out_status;

endmodule
